/* design/csd_pkg.sv */
`default_nettype none
package csd_pkg;

   localparam int COORD_BITS = 14;
   localparam int FRAC_BITS  = 16;
   localparam int CEN_BITS   = 12;
   localparam int RAD_BITS   = 11;
   localparam int RSQ_BITS   = 2 * RAD_BITS;

   // derived datapath widths
   localparam int DW    = COORD_BITS + 1;                          // end - start
   localparam int FW    = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1; // start - center
   localparam int SQW   = 2 * FW;
   localparam int PW    = FW + DW;
   localparam int BW    = PW + 2;
   localparam int AW    = 2 * DW;
   localparam int CW    = SQW + 2;
   localparam int ACW   = AW + 1 + CW;
   localparam int DISCW = ((2 * BW > ACW + 2) ? 2 * BW : ACW + 2) + 1;
   localparam int RW    = DISCW / 2;
   localparam int NW    = ((BW > RW + 1) ? BW : RW + 1) + 2;
   localparam int DENW  = AW + 1;
   localparam int QW    = FRAC_BITS + 1;
   localparam int MW    = DW + QW + 1;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;
   localparam logic [1:0] REG_CENTER_X    = 2'd0;
   localparam logic [1:0] REG_CENTER_Y    = 2'd1;
   localparam logic [1:0] REG_RING_RADIUS = 2'd2;

   localparam logic [CEN_BITS-1:0] CENTER_X_RESET    = CEN_BITS'(160);
   localparam logic [CEN_BITS-1:0] CENTER_Y_RESET    = CEN_BITS'(160);
   localparam logic [RAD_BITS-1:0] RING_RADIUS_RESET = RAD_BITS'(120);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [CEN_BITS-1:0] cx;
      logic [CEN_BITS-1:0] cy;
      logic [RAD_BITS-1:0] r;
   } cfg_type;

   typedef struct packed {
      coord_type             x0;
      coord_type             y0;
      logic signed [DW-1:0]  dx;
      logic signed [DW-1:0]  dy;
   } seg_type;

   typedef struct packed {
      seg_type               seg;
      logic                  p0_in;
      logic                  p1_in;
      logic                  a_zero;
      logic                  disc_neg;
      logic signed [BW-1:0]  b;
      logic [AW-1:0]         a;
   } sqrt_side_type;

   typedef struct packed {
      sqrt_side_type         side;
      logic [DISCW-1:0]      disc;
   } front_type;

   typedef struct packed {
      sqrt_side_type         side;
      logic [RW-1:0]         s;
   } root_type;

   typedef struct packed {
      seg_type               seg;
      logic                  vis;
      logic [DENW-1:0]       num_a;
      logic [DENW-1:0]       num_b;
      logic [DENW-1:0]       den;
   } span_type;

   typedef struct packed {
      seg_type               seg;
      logic                  vis;
      logic [QW-1:0]         ta;
      logic [QW-1:0]         tb;
   } tpar_type;

endpackage
`default_nettype wire

/* design/csd_req_if.sv */
`default_nettype none
interface csd_req_if import csd_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;

   modport source (output valid, output start_x, output start_y, output end_x, output end_y,
                   input ready);
   modport sink   (input valid, input start_x, input start_y, input end_x, input end_y,
                   output ready);
endinterface
`default_nettype wire

/* design/csd_rsp_if.sv */
`default_nettype none
interface csd_rsp_if import csd_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      visible;
   coord_type clip_start_x;
   coord_type clip_start_y;
   coord_type clip_end_x;
   coord_type clip_end_y;

   modport source (output valid, output visible, output clip_start_x, output clip_start_y,
                   output clip_end_x, output clip_end_y, input ready);
   modport sink   (input valid, input visible, input clip_start_x, input clip_start_y,
                   input clip_end_x, input clip_end_y, output ready);
endinterface
`default_nettype wire

/* design/csd_csr.sv */
`default_nettype none
module csd_csr import csd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   logic [CEN_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [RAD_BITS-1:0] r_ff, r_in;
   logic                wr;

   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      r_in  = r_ff;
      if (wr) begin
         unique case (paddr[CSR_AW-1:2])
            REG_CENTER_X:    cx_in = pwdata[CEN_BITS-1:0];
            REG_CENTER_Y:    cy_in = pwdata[CEN_BITS-1:0];
            REG_RING_RADIUS: r_in  = pwdata[RAD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= CENTER_X_RESET;
         cy_ff <= CENTER_Y_RESET;
         r_ff  <= RING_RADIUS_RESET;
      end else begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         r_ff  <= r_in;
      end
   end

   always_comb begin
      unique case (paddr[CSR_AW-1:2])
         REG_CENTER_X:    prdata = CSR_DW'(cx_ff);
         REG_CENTER_Y:    prdata = CSR_DW'(cy_ff);
         REG_RING_RADIUS: prdata = CSR_DW'(r_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.cx = cx_ff;
   assign cfg.cy = cy_ff;
   assign cfg.r  = r_ff;

endmodule
`default_nettype wire

/* design/csd_front.sv */
`default_nettype none
module csd_front import csd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  en,
   input  wire logic  in_valid,
   input  coord_type  x0,
   input  coord_type  y0,
   input  coord_type  x1,
   input  coord_type  y1,
   input  cfg_type    cfg,
   output logic       out_valid,
   output front_type  out_data
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // stage 1: offsets
   seg_type              seg1_ff, seg1_in;
   logic signed [FW-1:0] fx_ff, fy_ff, gx_ff, gy_ff, fx_in, fy_in, gx_in, gy_in;
   logic [RSQ_BITS-1:0]  rsq1_ff, rsq1_in;

   always_comb begin
      logic signed [FW-1:0] cxs, cys;
      cxs = FW'($signed({1'b0, cfg.cx}));
      cys = FW'($signed({1'b0, cfg.cy}));
      seg1_in.x0 = x0;
      seg1_in.y0 = y0;
      seg1_in.dx = DW'(x1) - DW'(x0);
      seg1_in.dy = DW'(y1) - DW'(y0);
      fx_in      = FW'(x0) - cxs;
      fy_in      = FW'(y0) - cys;
      gx_in      = FW'(x1) - cxs;
      gy_in      = FW'(y1) - cys;
      rsq1_in    = RSQ_BITS'(cfg.r) * RSQ_BITS'(cfg.r);
   end

   // stage 2: products
   seg_type              seg2_ff;
   logic [RSQ_BITS-1:0]  rsq2_ff;
   logic [SQW-1:0]       fx2_ff, fy2_ff, gx2_ff, gy2_ff, fx2_in, fy2_in, gx2_in, gy2_in;
   logic [AW-1:0]        dx2_ff, dy2_ff, dx2_in, dy2_in;
   logic signed [PW-1:0] fxdx_ff, fydy_ff, fxdx_in, fydy_in;

   always_comb begin
      logic signed [SQW-1:0] fxs, fys, gxs, gys;
      logic signed [AW-1:0]  dxa, dya;
      logic signed [PW-1:0]  fxp, fyp, dxp, dyp;
      fxs = SQW'(fx_ff);
      fys = SQW'(fy_ff);
      gxs = SQW'(gx_ff);
      gys = SQW'(gy_ff);
      dxa = AW'(seg1_ff.dx);
      dya = AW'(seg1_ff.dy);
      fxp = PW'(fx_ff);
      fyp = PW'(fy_ff);
      dxp = PW'(seg1_ff.dx);
      dyp = PW'(seg1_ff.dy);
      fx2_in  = $unsigned(fxs * fxs);
      fy2_in  = $unsigned(fys * fys);
      gx2_in  = $unsigned(gxs * gxs);
      gy2_in  = $unsigned(gys * gys);
      dx2_in  = $unsigned(dxa * dxa);
      dy2_in  = $unsigned(dya * dya);
      fxdx_in = fxp * dxp;
      fydy_in = fyp * dyp;
   end

   // stage 3: quadratic coefficients and inside tests
   seg_type              seg3_ff;
   logic                 p0_3_ff, p1_3_ff, p0_3_in, p1_3_in;
   logic [AW-1:0]        a3_ff, a3_in;
   logic signed [BW-1:0] b3_ff, b3_in;
   logic signed [CW-1:0] c3_ff, c3_in;

   always_comb begin
      logic [SQW:0] d0, d1;
      d0      = {1'b0, fx2_ff} + {1'b0, fy2_ff};
      d1      = {1'b0, gx2_ff} + {1'b0, gy2_ff};
      p0_3_in = d0 <= (SQW + 1)'(rsq2_ff);
      p1_3_in = d1 <= (SQW + 1)'(rsq2_ff);
      a3_in   = dx2_ff + dy2_ff;
      b3_in   = (BW'(fxdx_ff) + BW'(fydy_ff)) <<< 1;
      c3_in   = $signed({1'b0, d0}) - $signed(CW'(rsq2_ff));
   end

   // stage 4: b^2 and a*c
   seg_type                 seg4_ff;
   logic                    p0_4_ff, p1_4_ff, az4_ff;
   logic [AW-1:0]           a4_ff;
   logic signed [BW-1:0]    b4_ff;
   logic signed [DISCW-1:0] bsq_ff, bsq_in;
   logic signed [ACW-1:0]   ac_ff, ac_in;

   always_comb begin
      logic signed [DISCW-1:0] bs;
      logic signed [ACW-1:0]   as, cs;
      bs     = DISCW'(b3_ff);
      as     = ACW'($signed({1'b0, a3_ff}));
      cs     = ACW'(c3_ff);
      bsq_in = bs * bs;
      ac_in  = as * cs;
   end

   // stage 5: discriminant
   front_type res_ff, res_in;

   always_comb begin
      logic signed [DISCW-1:0] disc;
      disc                 = bsq_ff - (DISCW'(ac_ff) <<< 2);
      res_in.side.seg      = seg4_ff;
      res_in.side.p0_in    = p0_4_ff;
      res_in.side.p1_in    = p1_4_ff;
      res_in.side.a_zero   = az4_ff;
      res_in.side.disc_neg = disc[DISCW-1];
      res_in.side.b        = b4_ff;
      res_in.side.a        = a4_ff;
      res_in.disc          = $unsigned(disc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         seg1_ff <= seg1_in;
         fx_ff   <= fx_in;
         fy_ff   <= fy_in;
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
         rsq1_ff <= rsq1_in;

         seg2_ff <= seg1_ff;
         rsq2_ff <= rsq1_ff;
         fx2_ff  <= fx2_in;
         fy2_ff  <= fy2_in;
         gx2_ff  <= gx2_in;
         gy2_ff  <= gy2_in;
         dx2_ff  <= dx2_in;
         dy2_ff  <= dy2_in;
         fxdx_ff <= fxdx_in;
         fydy_ff <= fydy_in;

         seg3_ff <= seg2_ff;
         p0_3_ff <= p0_3_in;
         p1_3_ff <= p1_3_in;
         a3_ff   <= a3_in;
         b3_ff   <= b3_in;
         c3_ff   <= c3_in;

         seg4_ff <= seg3_ff;
         p0_4_ff <= p0_3_ff;
         p1_4_ff <= p1_3_ff;
         az4_ff  <= (a3_ff == '0);
         a4_ff   <= a3_ff;
         b4_ff   <= b3_ff;
         bsq_ff  <= bsq_in;
         ac_ff   <= ac_in;

         res_ff  <= res_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = res_ff;

endmodule
`default_nettype wire

/* design/csd_sqrt.sv */
`default_nettype none
module csd_sqrt import csd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire logic in_valid,
   input  front_type in_data,
   output logic      out_valid,
   output root_type  out_data
);

   // one root bit per stage, most significant first
   logic          v_ff    [RW];
   sqrt_side_type side_ff [RW];
   logic [DISCW-1:0] rem_ff [RW];
   logic [RW-1:0]    root_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      localparam int BIT = RW - 1 - k;
      logic             v_prev;
      sqrt_side_type    side_prev;
      logic [DISCW-1:0] rem_prev;
      logic [RW-1:0]    root_prev;
      logic [DISCW:0]   trial;
      logic [DISCW-1:0] rem_in;
      logic [RW-1:0]    root_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign side_prev = in_data.side;
         assign rem_prev  = in_data.disc;
         assign root_prev = '0;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // (q + 2^i)^2 - q^2 = q*2^(i+1) + 2^(2i)
      always_comb begin
         trial = ((DISCW + 1)'(root_prev) << (BIT + 1)) + ((DISCW + 1)'(1) << (2 * BIT));
         if ({1'b0, rem_prev} >= trial) begin
            rem_in  = DISCW'({1'b0, rem_prev} - trial);
            root_in = root_prev | (RW'(1) << BIT);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_prev;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign out_valid     = v_ff[RW-1];
   assign out_data.side = side_ff[RW-1];
   assign out_data.s    = root_ff[RW-1];

endmodule
`default_nettype wire

/* design/csd_clip.sv */
`default_nettype none
module csd_clip import csd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire logic in_valid,
   input  root_type  in_data,
   output logic      out_valid,
   output span_type  out_data
);

   logic                 v1_ff, v2_ff;
   seg_type              seg_ff;
   logic                 bad_ff, bad_in;
   logic signed [NW-1:0] na_ff, nb_ff, na_in, nb_in;
   logic [DENW-1:0]      den_ff, den_in;
   span_type             res_ff, res_in;

   // stage 1: raw root numerators over den = 2a
   always_comb begin
      logic signed [NW-1:0] bn, sx;
      logic                 p0, p1;
      p0     = in_data.side.p0_in;
      p1     = in_data.side.p1_in;
      bn     = -NW'(in_data.side.b);
      sx     = NW'($signed({1'b0, in_data.s}));
      // both-inside with a point segment still needs a nonzero divisor
      den_in = in_data.side.a_zero ? DENW'(2) : {in_data.side.a, 1'b0};
      na_in  = p0 ? '0 : bn - sx;
      nb_in  = p1 ? NW'($signed({1'b0, den_in})) : bn + sx;
      bad_in = !(p0 && p1) && (in_data.side.a_zero || in_data.side.disc_neg);
   end

   // stage 2: range tests and clamping
   always_comb begin
      logic signed [NW-1:0] dens, nac, nbc;
      dens = NW'($signed({1'b0, den_ff}));
      nac  = (na_ff < 0) ? '0 : na_ff;
      nbc  = (nb_ff > dens) ? dens : nb_ff;
      res_in.seg   = seg_ff;
      res_in.vis   = !(bad_ff || (nb_ff < 0) || (na_ff > dens) || (nac > nbc));
      res_in.num_a = DENW'(nac);
      res_in.num_b = DENW'(nbc);
      res_in.den   = den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         seg_ff <= in_data.side.seg;
         bad_ff <= bad_in;
         na_ff  <= na_in;
         nb_ff  <= nb_in;
         den_ff <= den_in;
         res_ff <= res_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = res_ff;

endmodule
`default_nettype wire

/* design/csd_div.sv */
`default_nettype none
module csd_div import csd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire logic in_valid,
   input  span_type  in_data,
   output logic      out_valid,
   output tpar_type  out_data
);

   typedef struct packed {
      seg_type         seg;
      logic            vis;
      logic [DENW-1:0] den;
      logic [DENW-1:0] ra;
      logic [DENW-1:0] rb;
      logic [QW-1:0]   qa;
      logic [QW-1:0]   qb;
   } dstage_type;

   logic       v_ff  [QW];
   dstage_type st_ff [QW];

   // restoring long division, one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int BIT = QW - 1 - k;
      logic            v_prev;
      dstage_type      prev, st_in;
      logic [DENW:0]   xa, xb, dx;
      logic            ga, gb;

      if (k == 0) begin : g_first
         assign v_prev     = in_valid;
         assign prev.seg   = in_data.seg;
         assign prev.vis   = in_data.vis;
         assign prev.den   = in_data.den;
         assign prev.ra    = in_data.num_a;
         assign prev.rb    = in_data.num_b;
         assign prev.qa    = '0;
         assign prev.qb    = '0;
         assign xa         = {1'b0, prev.ra};
         assign xb         = {1'b0, prev.rb};
      end else begin : g_next
         assign v_prev = v_ff[k-1];
         assign prev   = st_ff[k-1];
         assign xa     = {prev.ra, 1'b0};
         assign xb     = {prev.rb, 1'b0};
      end

      always_comb begin
         dx       = {1'b0, prev.den};
         ga       = xa >= dx;
         gb       = xb >= dx;
         st_in    = prev;
         st_in.ra = ga ? DENW'(xa - dx) : DENW'(xa);
         st_in.rb = gb ? DENW'(xb - dx) : DENW'(xb);
         st_in.qa = prev.qa | (ga ? (QW'(1) << BIT) : '0);
         st_in.qb = prev.qb | (gb ? (QW'(1) << BIT) : '0);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= st_in;
         end
      end
   end

   // round to nearest, ties up: bump when twice the remainder reaches den
   logic     vr_ff;
   tpar_type res_ff, res_in;

   always_comb begin
      dstage_type    last;
      logic [DENW:0] dx;
      last       = st_ff[QW-1];
      dx         = {1'b0, last.den};
      res_in.seg = last.seg;
      res_in.ta  = last.qa + QW'({last.ra, 1'b0} >= dx);
      res_in.tb  = last.qb + QW'({last.rb, 1'b0} >= dx);
      res_in.vis = last.vis && !(res_in.ta > res_in.tb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
      end else if (en) begin
         vr_ff <= v_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = vr_ff;
   assign out_data  = res_ff;

endmodule
`default_nettype wire

/* design/csd_interp.sv */
`default_nettype none
module csd_interp import csd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire logic in_valid,
   input  tpar_type  in_data,
   output logic      out_valid,
   output logic      visible,
   output coord_type clip_start_x,
   output coord_type clip_start_y,
   output coord_type clip_end_x,
   output coord_type clip_end_y
);

   localparam logic [MW-1:0] HALF = MW'(1) << (FRAC_BITS - 1);

   // {sign, round_half_away(|p| / 2^FRAC_BITS)}
   function automatic logic [DW:0] round_mag(input logic signed [MW-1:0] p);
      logic [MW-1:0] mag, sum;
      mag = (p < 0) ? $unsigned(-p) : $unsigned(p);
      sum = (mag + HALF) >> FRAC_BITS;
      return {p[MW-1], sum[DW-1:0]};
   endfunction

   function automatic coord_type apply(input coord_type base, input logic [DW:0] rm);
      logic signed [DW:0] bs, rs, res;
      bs  = (DW + 1)'(base);
      rs  = $signed({1'b0, rm[DW-1:0]});
      res = rm[DW] ? bs - rs : bs + rs;
      return res[COORD_BITS-1:0];
   endfunction

   logic v1_ff, v2_ff, v3_ff;

   // stage 1: d * t
   coord_type            x0_1_ff, y0_1_ff;
   logic                 vis1_ff;
   logic signed [MW-1:0] pxa_ff, pya_ff, pxb_ff, pyb_ff, pxa_in, pya_in, pxb_in, pyb_in;

   always_comb begin
      logic signed [MW-1:0] dxm, dym, tam, tbm;
      dxm    = MW'(in_data.seg.dx);
      dym    = MW'(in_data.seg.dy);
      tam    = MW'($signed({1'b0, in_data.ta}));
      tbm    = MW'($signed({1'b0, in_data.tb}));
      pxa_in = dxm * tam;
      pya_in = dym * tam;
      pxb_in = dxm * tbm;
      pyb_in = dym * tbm;
   end

   // stage 2: rounded magnitudes
   coord_type   x0_2_ff, y0_2_ff;
   logic        vis2_ff;
   logic [DW:0] rxa_ff, rya_ff, rxb_ff, ryb_ff;

   // stage 3: output register
   logic      vis3_ff;
   coord_type csx_ff, csy_ff, cex_ff, cey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_1_ff <= in_data.seg.x0;
         y0_1_ff <= in_data.seg.y0;
         vis1_ff <= in_data.vis;
         pxa_ff  <= pxa_in;
         pya_ff  <= pya_in;
         pxb_ff  <= pxb_in;
         pyb_ff  <= pyb_in;

         x0_2_ff <= x0_1_ff;
         y0_2_ff <= y0_1_ff;
         vis2_ff <= vis1_ff;
         rxa_ff  <= round_mag(pxa_ff);
         rya_ff  <= round_mag(pya_ff);
         rxb_ff  <= round_mag(pxb_ff);
         ryb_ff  <= round_mag(pyb_ff);

         vis3_ff <= vis2_ff;
         csx_ff  <= vis2_ff ? apply(x0_2_ff, rxa_ff) : '0;
         csy_ff  <= vis2_ff ? apply(y0_2_ff, rya_ff) : '0;
         cex_ff  <= vis2_ff ? apply(x0_2_ff, rxb_ff) : '0;
         cey_ff  <= vis2_ff ? apply(y0_2_ff, ryb_ff) : '0;
      end
   end

   assign out_valid    = v3_ff;
   assign visible      = vis3_ff;
   assign clip_start_x = csx_ff;
   assign clip_start_y = csy_ff;
   assign clip_end_x   = cex_ff;
   assign clip_end_y   = cey_ff;

endmodule
`default_nettype wire

/* design/clip_segment_to_disc_top.sv */
`default_nettype none
// Channel   Ports       Direction  Payload
// request   req_chan    in         start_x, start_y, end_x, end_y
// response  rsp_chan    out        visible, clip_start_x/y, clip_end_x/y
// control   csr_*       in/out     center_x @0x0, center_y @0x4, ring_radius @0x8
//
// One segment per cycle unless stalled; 5 geometry stages, one stage
// per root bit of the discriminant square root (33), 2 clip stages, 18 divider
// stages for the Q1.16 parameters and 3 interpolation stages.
// Synchronous active-high reset clears the valid bits and the CSR registers only.
// A result held in the output register and not taken stalls every stage at once;
// req_chan.ready is low only then.
module clip_segment_to_disc_top import csd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   csd_req_if.sink                req_chan,
   csd_rsp_if.source              rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   cfg_type   cfg;
   logic      en;
   logic      fr_valid, sq_valid, cl_valid, dv_valid, out_valid;
   front_type fr_data;
   root_type  sq_data;
   span_type  cl_data;
   tpar_type  dv_data;

   assign en             = !out_valid || rsp_chan.ready;
   assign req_chan.ready = en;
   assign rsp_chan.valid = out_valid;

   csd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   csd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .x0        (req_chan.start_x),
      .y0        (req_chan.start_y),
      .x1        (req_chan.end_x),
      .y1        (req_chan.end_y),
      .cfg       (cfg),
      .out_valid (fr_valid),
      .out_data  (fr_data)
   );

   csd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_data   (fr_data),
      .out_valid (sq_valid),
      .out_data  (sq_data)
   );

   csd_clip u_clip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_data   (sq_data),
      .out_valid (cl_valid),
      .out_data  (cl_data)
   );

   csd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cl_valid),
      .in_data   (cl_data),
      .out_valid (dv_valid),
      .out_data  (dv_data)
   );

   csd_interp u_interp (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (dv_valid),
      .in_data      (dv_data),
      .out_valid    (out_valid),
      .visible      (rsp_chan.visible),
      .clip_start_x (rsp_chan.clip_start_x),
      .clip_start_y (rsp_chan.clip_start_y),
      .clip_end_x   (rsp_chan.clip_end_x),
      .clip_end_y   (rsp_chan.clip_end_y)
   );

endmodule
`default_nettype wire

/* test/tb_clip_segment_to_disc_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_clip_segment_to_disc_top;
   import csd_pkg::*;

   typedef struct packed {
      logic      visible;
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
   } clip_result_type;

   typedef struct {
      coord_type       x0;
      coord_type       y0;
      coord_type       x1;
      coord_type       y1;
      logic            known;
      clip_result_type res;
   } seg_row_type;

   localparam int LATENCY     = 61;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csd_req_if req_chan ();
   csd_rsp_if rsp_chan ();

   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   clip_segment_to_disc_top dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor's copy of the registers
   longint disc_cx = 160;
   longint disc_cy = 160;
   longint disc_r  = 120;

   clip_result_type clip_queue[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  idle_pct    = 7;
   bit  hold_rsp    = 1'b0;

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.start_x = '0;
      req_chan.start_y = '0;
      req_chan.end_x   = '0;
      req_chan.end_y   = '0;
      rsp_chan.ready   = 1'b0;
   end

   function automatic longint floor_sqrt(longint v);
      longint res = 0;
      longint bitv = longint'(1) << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint lerp_coord(longint base, longint d, longint tq);
      longint p = d * tq;
      longint mag = (p < 0) ? -p : p;
      longint rr = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      return (p < 0) ? base - rr : base + rr;
   endfunction

   function automatic clip_result_type clip_segment(coord_type ix0, coord_type iy0,
                                                    coord_type ix1, coord_type iy1);
      clip_result_type o = '0;
      longint x0 = ix0, y0 = iy0, x1 = ix1, y1 = iy1;
      longint fx = x0 - disc_cx, fy = y0 - disc_cy;
      longint gx = x1 - disc_cx, gy = y1 - disc_cy;
      longint rsq = disc_r * disc_r;
      longint dx = x1 - x0, dy = y1 - y0;
      bit in0 = (fx * fx + fy * fy) <= rsq;
      bit in1 = (gx * gx + gy * gy) <= rsq;
      longint ta, tb, a, b, c, disc, s, den, na, nb;
      if (in0 && in1) begin
         ta = 0;
         tb = longint'(1) << FRAC_BITS;
      end else begin
         a = dx * dx + dy * dy;
         if (a == 0) return o;
         b = 2 * (fx * dx + fy * dy);
         c = fx * fx + fy * fy - rsq;
         disc = b * b - 4 * a * c;
         if (disc < 0) return o;
         s = floor_sqrt(disc);
         den = 2 * a;
         na = in0 ? 0 : (-b - s);
         nb = in1 ? den : (-b + s);
         if (nb < 0 || na > den) return o;
         if (na < 0) na = 0;
         if (nb > den) nb = den;
         if (na > nb) return o;
         ta = ((na << (FRAC_BITS + 1)) + den) / (2 * den);
         tb = ((nb << (FRAC_BITS + 1)) + den) / (2 * den);
         if (ta > tb) return o;
      end
      o.visible = 1'b1;
      o.sx = coord_type'(lerp_coord(x0, dx, ta));
      o.sy = coord_type'(lerp_coord(y0, dy, ta));
      o.ex = coord_type'(lerp_coord(x0, dx, tb));
      o.ey = coord_type'(lerp_coord(y0, dy, tb));
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   task automatic csr_write(logic [1:0] idx, logic [CSR_DW-1:0] value);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_CENTER_X:    disc_cx = value & 32'hFFF;
         REG_CENTER_Y:    disc_cy = value & 32'hFFF;
         REG_RING_RADIUS: disc_r  = value & 32'h7FF;
         default: ;
      endcase
   endtask

   task automatic send_segment(coord_type x0, coord_type y0, coord_type x1, coord_type y1,
                               bit known, clip_result_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.start_x <= x0;
      req_chan.start_y <= y0;
      req_chan.end_x   <= x1;
      req_chan.end_y   <= y1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      clip_queue.push_back(known ? want : clip_segment(x0, y0, x1, y1));
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (clip_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic coord_type rand_coord();
      return coord_type'($urandom);
   endfunction

   function automatic coord_type near_coord(longint c, longint span);
      longint v = c + longint'($urandom_range(2 * span)) - span;
      if (v > 8191) v = 8191;
      if (v < -8192) v = -8192;
      return coord_type'(v);
   endfunction

   // result side
   always @(posedge clock) begin
      clip_result_type got, want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.visible, rsp_chan.clip_start_x, rsp_chan.clip_start_y,
                   rsp_chan.clip_end_x, rsp_chan.clip_end_y};
            if (clip_queue.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = clip_queue.pop_front();
               if (got.visible != want.visible)
                  report_mismatch("visible", got.visible, want.visible);
               if (got.sx != want.sx) report_mismatch("clip_start_x", got.sx, want.sx);
               if (got.sy != want.sy) report_mismatch("clip_start_y", got.sy, want.sy);
               if (got.ex != want.ex) report_mismatch("clip_end_x", got.ex, want.ex);
               if (got.ey != want.ey) report_mismatch("clip_end_y", got.ey, want.ey);
            end
         end
         rsp_chan.ready <= !hold_rsp && ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   seg_row_type seg_table[] = '{
      '{0, 0, 0, 0, 1'b1, '{1'b0, 0, 0, 0, 0}},               // degenerate outside
      '{160, 160, 160, 160, 1'b1, '{1'b1, 160, 160, 160, 160}}, // degenerate inside
      '{150, 150, 170, 170, 1'b1, '{1'b1, 150, 150, 170, 170}}, // both inside
      '{-8192, -8192, -8192, 8191, 1'b1, '{1'b0, 0, 0, 0, 0}},  // no crossing
      '{8191, 8191, -8192, -8192, 1'b0, '0},
      '{-8192, 160, 8191, 160, 1'b0, '0},
      '{160, -8192, 160, 8191, 1'b0, '0},
      '{0, 0, 20, 20, 1'b1, '{1'b0, 0, 0, 0, 0}},               // crossing beyond end
      '{400, 400, 350, 350, 1'b1, '{1'b0, 0, 0, 0, 0}},         // crossing beyond end
      '{160, 160, 8191, 8191, 1'b0, '0},
      '{8191, -8192, 160, 160, 1'b0, '0},
      '{40, 0, 40, 400, 1'b0, '0},                              // tangent
      '{280, 160, 280, 160, 1'b1, '{1'b1, 280, 160, 280, 160}}, // on the ring
      '{0, 160, 400, 160, 1'b0, '0},
      '{-1, -1, 1, 1, 1'b0, '0}
   };

   initial begin
      int n;
      int kind;
      longint cx, cy, rr;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (seg_table[i])
         send_segment(seg_table[i].x0, seg_table[i].y0, seg_table[i].x1, seg_table[i].y1,
                      seg_table[i].known, seg_table[i].res);
      drain_results();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin cx = 0;    cy = 4095; rr = 1;    end
            1: begin cx = 4095; cy = 0;    rr = 2047; end
            2: begin cx = 2000; cy = 100;  rr = 0;    end
            3: begin cx = 160;  cy = 160;  rr = 120;  end
            default: begin
               cx = $urandom_range(4095);
               cy = $urandom_range(4095);
               rr = $urandom_range(2047, 1);
            end
         endcase
         csr_write(REG_CENTER_X, 32'(cx) | ($urandom & 32'hFFFF_F000));
         csr_write(REG_CENTER_Y, 32'(cy));
         csr_write(REG_RING_RADIUS, 32'(rr));
         idle_pct = (phase == 4) ? 0 : 7;
         if (phase == 5) begin
            // long receiver hold-off while requests keep coming
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         for (n = 0; n < 250; n++) begin
            kind = $urandom_range(9);
            if (kind < 6)
               send_segment(near_coord(cx, rr + 40), near_coord(cy, rr + 40),
                            near_coord(cx, rr + 40), near_coord(cy, rr + 40), 1'b0, '0);
            else if (kind < 8)
               send_segment(near_coord(cx, 3 * rr + 8), near_coord(cy, 3 * rr + 8),
                            near_coord(cx, 3 * rr + 8), near_coord(cy, 3 * rr + 8),
                            1'b0, '0);
            else
               send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            1'b0, '0);
            if (n == 120) drain_results();
         end
         drain_results();
      end

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
